FILE: rtl/core/pccc_pkg.sv
`timescale 1ns / 1ps

package pccc_pkg;

	localparam int unsigned COMP_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_COMPONENTS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEST_COMPONENTS = 2'd1;

	localparam logic [CFG_DATA_W-1:0] SOURCE_COMPONENTS_RESET = 3'd1;
	localparam logic [CFG_DATA_W-1:0] DEST_COMPONENTS_RESET = 3'd4;

	// layout code: component count minus one
	typedef logic [1:0] layout_t;
	localparam layout_t LAYOUT_GREY = 2'd0;
	localparam layout_t LAYOUT_GREY_ALPHA = 2'd1;
	localparam layout_t LAYOUT_RGB = 2'd2;
	localparam layout_t LAYOUT_RGBA = 2'd3;

	localparam logic [COMP_W-1:0] LUMA_R = 8'd77;
	localparam logic [COMP_W-1:0] LUMA_G = 8'd150;
	localparam logic [COMP_W-1:0] LUMA_B = 8'd29;
	localparam int unsigned LUMA_SHIFT = 8;
	localparam logic [COMP_W-1:0] FULL = 8'd255;

	typedef struct packed {
		logic [COMP_W-1:0] in_comp0;
		logic [COMP_W-1:0] in_comp1;
		logic [COMP_W-1:0] in_comp2;
		logic [COMP_W-1:0] in_comp3;
		logic              in_last;
	} pix_in_t;

	typedef struct packed {
		logic [COMP_W-1:0] out_comp0;
		logic [COMP_W-1:0] out_comp1;
		logic [COMP_W-1:0] out_comp2;
		logic [COMP_W-1:0] out_comp3;
		logic              out_last;
	} pix_out_t;

	typedef struct packed {
		layout_t src;
		layout_t dst;
	} layout_cfg_t;

endpackage

FILE: rtl/core/pccc_convert.sv
`timescale 1ns / 1ps

module pccc_convert (
	input  pccc_pkg::layout_cfg_t cfg,
	input  pccc_pkg::pix_in_t     pix,
	output pccc_pkg::pix_out_t    res
);

	localparam int unsigned SUM_W = 2 * pccc_pkg::COMP_W;

	logic [SUM_W-1:0]            luma_sum;
	logic [pccc_pkg::COMP_W-1:0] luma;
	logic [pccc_pkg::COMP_W-1:0] alpha;
	logic [pccc_pkg::COMP_W-1:0] d0, d1, d2, d3;
	logic                        src_grey;

	always_comb begin
		luma_sum = SUM_W'(pix.in_comp0) * SUM_W'(pccc_pkg::LUMA_R)
			+ SUM_W'(pix.in_comp1) * SUM_W'(pccc_pkg::LUMA_G)
			+ SUM_W'(pix.in_comp2) * SUM_W'(pccc_pkg::LUMA_B);
		luma = luma_sum[pccc_pkg::LUMA_SHIFT +: pccc_pkg::COMP_W];
	end

	always_comb begin
		src_grey = (cfg.src == pccc_pkg::LAYOUT_GREY)
			|| (cfg.src == pccc_pkg::LAYOUT_GREY_ALPHA);
		if (cfg.src == pccc_pkg::LAYOUT_GREY_ALPHA) begin
			alpha = pix.in_comp1;
		end else if (cfg.src == pccc_pkg::LAYOUT_RGBA) begin
			alpha = pix.in_comp3;
		end else begin
			alpha = pccc_pkg::FULL;
		end

		d0 = '0;
		d1 = '0;
		d2 = '0;
		d3 = '0;
		if (cfg.src == cfg.dst) begin
			d0 = pix.in_comp0;
			if (cfg.dst != pccc_pkg::LAYOUT_GREY) d1 = pix.in_comp1;
			if (cfg.dst[1]) d2 = pix.in_comp2;
			if (cfg.dst == pccc_pkg::LAYOUT_RGBA) d3 = pix.in_comp3;
		end else if (src_grey) begin
			unique case (cfg.dst)
				pccc_pkg::LAYOUT_GREY: begin
					d0 = pix.in_comp0;
				end
				pccc_pkg::LAYOUT_GREY_ALPHA: begin
					d0 = pix.in_comp0;
					d1 = alpha;
				end
				pccc_pkg::LAYOUT_RGB: begin
					d0 = pix.in_comp0;
					d1 = pix.in_comp0;
					d2 = pix.in_comp0;
				end
				default: begin
					// font-atlas rule for a grey source: white glyph, coverage in alpha; grey+alpha copies grey and keeps alpha
					if (cfg.src == pccc_pkg::LAYOUT_GREY) begin
						d0 = pccc_pkg::FULL;
						d1 = pccc_pkg::FULL;
						d2 = pccc_pkg::FULL;
						d3 = pix.in_comp0;
					end else begin
						d0 = pix.in_comp0;
						d1 = pix.in_comp0;
						d2 = pix.in_comp0;
						d3 = alpha;
					end
				end
			endcase
		end else begin
			unique case (cfg.dst)
				pccc_pkg::LAYOUT_GREY: begin
					d0 = luma;
				end
				pccc_pkg::LAYOUT_GREY_ALPHA: begin
					d0 = luma;
					d1 = alpha;
				end
				pccc_pkg::LAYOUT_RGB: begin
					d0 = pix.in_comp0;
					d1 = pix.in_comp1;
					d2 = pix.in_comp2;
				end
				default: begin
					d0 = pix.in_comp0;
					d1 = pix.in_comp1;
					d2 = pix.in_comp2;
					d3 = alpha;
				end
			endcase
		end
	end

	assign res.out_comp0 = d0;
	assign res.out_comp1 = d1;
	assign res.out_comp2 = d2;
	assign res.out_comp3 = d3;
	assign res.out_last  = pix.in_last;

endmodule

FILE: rtl/core/pixel_component_count_converter.sv
`timescale 1ns / 1ps

// Pixel component count converter.
// Input channel in_valid/in_stall/in_data carries one pixel per transfer in
// the configured source layout; output channel out_valid/out_stall/out_data
// carries the same pixel in the destination layout, with in_last copied.
// The configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes
// source_components (index 0) or dest_components (index 1); it is always
// ready and must only be used while no pixel is in flight. Counts of 0 act
// as 1 and counts above 4 act as 4. Other indexes are ignored.
// Path: an input register, then the lane mux and luma multiply-add, then
// the result register, which drives out_valid and out_data. Throughput is
// one pixel per cycle while out_stall is low; the result register is the
// limiting stage. While out_stall holds a result, an empty input register
// still takes one more pixel before in_stall rises. Reset clears both
// stages and restores the counts to 1 (source) and 4 (destination).
module pixel_component_count_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pccc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pccc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  pccc_pkg::pix_in_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output pccc_pkg::pix_out_t                  out_data
);

	function automatic pccc_pkg::layout_t to_layout(
		input logic [pccc_pkg::CFG_DATA_W-1:0] v
	);
		pccc_pkg::layout_t l;
		if (v == '0) begin
			l = pccc_pkg::LAYOUT_GREY;
		end else if (v > pccc_pkg::CFG_DATA_W'(4)) begin
			l = pccc_pkg::LAYOUT_RGBA;
		end else begin
			l = 2'(v - pccc_pkg::CFG_DATA_W'(1));
		end
		return l;
	endfunction

	pccc_pkg::layout_cfg_t cfg_q;
	pccc_pkg::pix_in_t     pix_s1;
	pccc_pkg::pix_out_t    res_s2;
	pccc_pkg::pix_out_t    conv;
	logic                  v_s1, v_s2;
	logic                  adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src <= to_layout(pccc_pkg::SOURCE_COMPONENTS_RESET);
			cfg_q.dst <= to_layout(pccc_pkg::DEST_COMPONENTS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == pccc_pkg::REG_SOURCE_COMPONENTS) cfg_q.src <= to_layout(cfg_data);
			if (cfg_index == pccc_pkg::REG_DEST_COMPONENTS) cfg_q.dst <= to_layout(cfg_data);
		end
	end

	assign adv_s1   = v_s1 && (!v_s2 || !out_stall);
	assign in_stall = v_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (!v_s2 || !out_stall) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) pix_s1 <= in_data;
		if (adv_s1) res_s2 <= conv;
	end

	pccc_convert u_convert (
		.cfg (cfg_q),
		.pix (pix_s1),
		.res (conv)
	);

	assign out_valid = v_s2;
	assign out_data  = res_s2;

	// a full pipe with a stalled result must hold off the input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && out_stall) |-> in_stall)
		else $error("input taken while both stages are held");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted pixel lost from input stage");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (out_valid && out_data.out_last == $past(pix_s1.in_last)))
		else $error("last flag not carried into result");

endmodule
